FILE: hw/rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

  localparam int CHAN_BITS   = 8;
  localparam int HUE_BITS    = 9;
  localparam int SECTOR_BITS = 3;
  localparam int REM_BITS    = 6;

  localparam int CHAN_MAX   = (1 << CHAN_BITS) - 1;
  localparam int SECTOR_DEG = 60;
  localparam int FULL_TURN  = 360;
  localparam int BIG        = CHAN_MAX * SECTOR_DEG;

  localparam int BIG_W    = $clog2(BIG + 1);
  localparam int PROD_P_W = 2 * CHAN_BITS;
  localparam int PROD_Q_W = CHAN_BITS + BIG_W;

  // Reciprocal constants: floor(2^k / d), with 2^k above every dividend, so the
  // estimate is the true quotient or one below it.
  localparam int RECIP_SHIFT = PROD_Q_W;
  localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam longint unsigned RECIP_MAX = RECIP_ONE / CHAN_MAX;
  localparam longint unsigned RECIP_BIG = RECIP_ONE / BIG;
  localparam int RECIP_PROD_W = RECIP_SHIFT + CHAN_BITS;

  localparam logic [SECTOR_BITS-1:0] SECT_RED_YELLOW    = 3'd0;
  localparam logic [SECTOR_BITS-1:0] SECT_YELLOW_GREEN  = 3'd1;
  localparam logic [SECTOR_BITS-1:0] SECT_GREEN_CYAN    = 3'd2;
  localparam logic [SECTOR_BITS-1:0] SECT_CYAN_BLUE     = 3'd3;
  localparam logic [SECTOR_BITS-1:0] SECT_BLUE_MAGENTA  = 3'd4;
  localparam logic [SECTOR_BITS-1:0] SECT_MAGENTA_RED   = 3'd5;

  typedef logic [CHAN_BITS-1:0] chan_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_converter_unit.sv
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid / in_stall  hue[8:0], saturation[7:0], value[7:0]
// out      out_valid/ out_stall red[7:0], green[7:0], blue[7:0], packed_color[23:0]
//
// Six-stage pipeline; one pixel per clock unless a stalled result holds it.
// Stages: sector split, saturation products, value products,
// reciprocal estimate, remainder correction, sector select.
// Synchronous reset clears all stage valid bits.
// A stalled result holds the whole pipeline; in_stall follows it combinationally.
module hsv_to_rgb_converter_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [hsv2rgb_pkg::HUE_BITS-1:0]     hue,
  input  wire logic [hsv2rgb_pkg::CHAN_BITS-1:0]    saturation,
  input  wire logic [hsv2rgb_pkg::CHAN_BITS-1:0]    value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [hsv2rgb_pkg::CHAN_BITS-1:0]         red,
  output logic [hsv2rgb_pkg::CHAN_BITS-1:0]         green,
  output logic [hsv2rgb_pkg::CHAN_BITS-1:0]         blue,
  output logic [3*hsv2rgb_pkg::CHAN_BITS-1:0]       packed_color
);

  localparam int CB   = hsv2rgb_pkg::CHAN_BITS;
  localparam int HB   = hsv2rgb_pkg::HUE_BITS;
  localparam int SB   = hsv2rgb_pkg::SECTOR_BITS;
  localparam int RB   = hsv2rgb_pkg::REM_BITS;
  localparam int BW   = hsv2rgb_pkg::BIG_W;
  localparam int PPW  = hsv2rgb_pkg::PROD_P_W;
  localparam int PQW  = hsv2rgb_pkg::PROD_Q_W;
  localparam int RPW  = hsv2rgb_pkg::RECIP_PROD_W;
  localparam int RSH  = hsv2rgb_pkg::RECIP_SHIFT;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: wrap hue, split into sector and remainder
  logic [HB-1:0] hue_w;
  logic [HB-1:0] sect_base;
  logic [SB-1:0] sect_c;

  always_comb begin
    if (hue >= HB'(hsv2rgb_pkg::FULL_TURN)) begin
      hue_w = hue - HB'(hsv2rgb_pkg::FULL_TURN);
    end else begin
      hue_w = hue;
    end
    priority if (hue_w >= HB'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sect_c    = hsv2rgb_pkg::SECT_MAGENTA_RED;
      sect_base = HB'(5 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_w >= HB'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sect_c    = hsv2rgb_pkg::SECT_BLUE_MAGENTA;
      sect_base = HB'(4 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_w >= HB'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sect_c    = hsv2rgb_pkg::SECT_CYAN_BLUE;
      sect_base = HB'(3 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_w >= HB'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sect_c    = hsv2rgb_pkg::SECT_GREEN_CYAN;
      sect_base = HB'(2 * hsv2rgb_pkg::SECTOR_DEG);
    end else if (hue_w >= HB'(hsv2rgb_pkg::SECTOR_DEG)) begin
      sect_c    = hsv2rgb_pkg::SECT_YELLOW_GREEN;
      sect_base = HB'(hsv2rgb_pkg::SECTOR_DEG);
    end else begin
      sect_c    = hsv2rgb_pkg::SECT_RED_YELLOW;
      sect_base = '0;
    end
  end

  logic          s1_valid;
  logic [SB-1:0] s1_sector;
  logic [RB-1:0] s1_rem;
  logic [CB-1:0] s1_sat;
  logic [CB-1:0] s1_val;
  logic [HB-1:0] rem_full;

  assign rem_full = hue_w - sect_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sector <= sect_c;
      s1_rem    <= rem_full[RB-1:0];
      s1_sat    <= saturation;
      s1_val    <= value;
    end
  end

  // stage 2: saturation terms
  logic          s2_valid;
  logic [SB-1:0] s2_sector;
  logic [CB-1:0] s2_val;
  logic [CB-1:0] s2_pnum;
  logic [BW-1:0] s2_sq;
  logic [BW-1:0] s2_st;
  logic [RB-1:0] rem_inv;

  assign rem_inv = RB'(hsv2rgb_pkg::SECTOR_DEG) - s1_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sector <= s1_sector;
      s2_val    <= s1_val;
      s2_pnum   <= CB'(hsv2rgb_pkg::CHAN_MAX) - s1_sat;
      s2_sq     <= BW'(s1_sat) * BW'(s1_rem);
      s2_st     <= BW'(s1_sat) * BW'(rem_inv);
    end
  end

  // stage 3: value products (dividends)
  logic           s3_valid;
  logic [SB-1:0]  s3_sector;
  logic [CB-1:0]  s3_val;
  logic [PPW-1:0] s3_xp;
  logic [PQW-1:0] s3_xq;
  logic [PQW-1:0] s3_xt;
  logic [BW-1:0]  qnum;
  logic [BW-1:0]  tnum;

  assign qnum = BW'(hsv2rgb_pkg::BIG) - s2_sq;
  assign tnum = BW'(hsv2rgb_pkg::BIG) - s2_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sector <= s2_sector;
      s3_val    <= s2_val;
      s3_xp     <= PPW'(s2_val) * PPW'(s2_pnum);
      s3_xq     <= PQW'(s2_val) * PQW'(qnum);
      s3_xt     <= PQW'(s2_val) * PQW'(tnum);
    end
  end

  // stage 4: quotient estimates by reciprocal multiply (may be one low)
  logic           s4_valid;
  logic [SB-1:0]  s4_sector;
  logic [CB-1:0]  s4_val;
  logic [PPW-1:0] s4_xp;
  logic [PQW-1:0] s4_xq;
  logic [PQW-1:0] s4_xt;
  logic [CB-1:0]  s4_ep;
  logic [CB-1:0]  s4_eq;
  logic [CB-1:0]  s4_et;
  logic [RPW-1:0] mp;
  logic [RPW-1:0] mq;
  logic [RPW-1:0] mt;

  assign mp = RPW'(s3_xp) * RPW'(hsv2rgb_pkg::RECIP_MAX);
  assign mq = RPW'(s3_xq) * RPW'(hsv2rgb_pkg::RECIP_BIG);
  assign mt = RPW'(s3_xt) * RPW'(hsv2rgb_pkg::RECIP_BIG);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
      s4_xp     <= s3_xp;
      s4_xq     <= s3_xq;
      s4_xt     <= s3_xt;
      s4_ep     <= mp[RSH +: CB];
      s4_eq     <= mq[RSH +: CB];
      s4_et     <= mt[RSH +: CB];
    end
  end

  // stage 5: remainder check, bump estimate by one when remainder >= divisor
  logic           s5_valid;
  logic [SB-1:0]  s5_sector;
  logic [CB-1:0]  s5_val;
  logic [CB-1:0]  s5_p;
  logic [CB-1:0]  s5_q;
  logic [CB-1:0]  s5_t;
  logic [PPW-1:0] rp;
  logic [PQW-1:0] rq;
  logic [PQW-1:0] rt;

  assign rp = s4_xp - PPW'(s4_ep) * PPW'(hsv2rgb_pkg::CHAN_MAX);
  assign rq = s4_xq - PQW'(s4_eq) * PQW'(hsv2rgb_pkg::BIG);
  assign rt = s4_xt - PQW'(s4_et) * PQW'(hsv2rgb_pkg::BIG);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sector <= s4_sector;
      s5_val    <= s4_val;
      s5_p      <= s4_ep + CB'(rp >= PPW'(hsv2rgb_pkg::CHAN_MAX));
      s5_q      <= s4_eq + CB'(rq >= PQW'(hsv2rgb_pkg::BIG));
      s5_t      <= s4_et + CB'(rt >= PQW'(hsv2rgb_pkg::BIG));
    end
  end

  // stage 6: sector select into the output register
  hsv2rgb_pkg::chan_t red_next;
  hsv2rgb_pkg::chan_t green_next;
  hsv2rgb_pkg::chan_t blue_next;

  always_comb begin
    unique case (s5_sector)
      hsv2rgb_pkg::SECT_RED_YELLOW: begin
        red_next = s5_val; green_next = s5_t;   blue_next = s5_p;
      end
      hsv2rgb_pkg::SECT_YELLOW_GREEN: begin
        red_next = s5_q;   green_next = s5_val; blue_next = s5_p;
      end
      hsv2rgb_pkg::SECT_GREEN_CYAN: begin
        red_next = s5_p;   green_next = s5_val; blue_next = s5_t;
      end
      hsv2rgb_pkg::SECT_CYAN_BLUE: begin
        red_next = s5_p;   green_next = s5_q;   blue_next = s5_val;
      end
      hsv2rgb_pkg::SECT_BLUE_MAGENTA: begin
        red_next = s5_t;   green_next = s5_p;   blue_next = s5_val;
      end
      default: begin
        red_next = s5_val; green_next = s5_p;   blue_next = s5_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign packed_color = {red, green, blue};

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_BITS    = hsv2rgb_pkg::HUE_BITS;
  localparam int CHAN_BITS   = hsv2rgb_pkg::CHAN_BITS;
  localparam int SECTOR_BITS = hsv2rgb_pkg::SECTOR_BITS;
  localparam int CHAN_MAX    = hsv2rgb_pkg::CHAN_MAX;
  localparam int SECTOR_DEG  = hsv2rgb_pkg::SECTOR_DEG;
  localparam int FULL_TURN   = hsv2rgb_pkg::FULL_TURN;
  localparam int BIG         = hsv2rgb_pkg::BIG;

  typedef hsv2rgb_pkg::chan_t chan_t;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 16;       // pipeline is 6 deep, leave margin
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_PIXELS = 1750;

  typedef struct packed {
    chan_t                   red;
    chan_t                   green;
    chan_t                   blue;
    logic [3*CHAN_BITS-1:0]  packed_color;
  } rgb_pixel_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [HUE_BITS-1:0]   hue = '0;
  chan_t                 saturation = '0;
  chan_t                 value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  chan_t                 red;
  chan_t                 green;
  chan_t                 blue;
  logic [3*CHAN_BITS-1:0] packed_color;

  rgb_pixel_t  pending_rgb[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_tick = 0;

  hsv_to_rgb_converter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .hue          (hue),
    .saturation   (saturation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .packed_color (packed_color)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Six-sector HSV to RGB with truncating integer divides.
  function automatic rgb_pixel_t predict_rgb(logic [HUE_BITS-1:0] h, chan_t s, chan_t v);
    rgb_pixel_t              px;
    int unsigned             deg;
    int unsigned             frac;
    int unsigned             p, q, t;
    logic [SECTOR_BITS-1:0]  sector;
    deg = h;
    if (deg >= FULL_TURN) deg -= FULL_TURN;
    sector = SECTOR_BITS'(deg / SECTOR_DEG);
    frac   = deg % SECTOR_DEG;
    p = (int'(v) * (CHAN_MAX - int'(s))) / CHAN_MAX;
    q = (int'(v) * (BIG - int'(s) * frac)) / BIG;
    t = (int'(v) * (BIG - int'(s) * (SECTOR_DEG - frac))) / BIG;
    case (sector)
      hsv2rgb_pkg::SECT_RED_YELLOW: begin
        px.red = v; px.green = chan_t'(t); px.blue = chan_t'(p);
      end
      hsv2rgb_pkg::SECT_YELLOW_GREEN: begin
        px.red = chan_t'(q); px.green = v; px.blue = chan_t'(p);
      end
      hsv2rgb_pkg::SECT_GREEN_CYAN: begin
        px.red = chan_t'(p); px.green = v; px.blue = chan_t'(t);
      end
      hsv2rgb_pkg::SECT_CYAN_BLUE: begin
        px.red = chan_t'(p); px.green = chan_t'(q); px.blue = v;
      end
      hsv2rgb_pkg::SECT_BLUE_MAGENTA: begin
        px.red = chan_t'(t); px.green = chan_t'(p); px.blue = v;
      end
      default: begin
        px.red = v; px.green = chan_t'(p); px.blue = chan_t'(q);
      end
    endcase
    px.packed_color = {px.red, px.green, px.blue};
    return px;
  endfunction

  // Input transfers queue a prediction; output transfers are checked against the oldest.
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst && in_valid && !in_stall)
      pending_rgb.push_back(predict_rgb(hue, saturation, value));
    if (!rst && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red);
          error_count++;
        end
        if (green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green);
          error_count++;
        end
        if (blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue);
          error_count++;
        end
        if (packed_color !== want.packed_color) begin
          $error("packed_color: expected %06h, got %06h", want.packed_color, packed_color);
          error_count++;
        end
      end
    end
  end

  // Receiver backpressure: stall_tick periodically redraws the pattern from four stall modes.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 255)
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall <= (stall_tick % 7 < 2);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_pixel(logic [HUE_BITS-1:0] h, chan_t s, chan_t v);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    value      <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic chan_t pick_channel();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return chan_t'(CHAN_MAX);
    return chan_t'($urandom_range(0, CHAN_MAX));
  endfunction

  task automatic test_sector_edges();
    int deg_list[12] = '{0, 1, 59, 60, 119, 120, 180, 239, 240, 300, 301, 359};
    foreach (deg_list[i])
      send_pixel(HUE_BITS'(deg_list[i]), chan_t'(CHAN_MAX), chan_t'(CHAN_MAX));
  endtask

  task automatic test_gray_and_black();
    send_pixel(HUE_BITS'(45), '0, chan_t'(CHAN_MAX));
    send_pixel(HUE_BITS'(200), '0, chan_t'(137));
    send_pixel(HUE_BITS'(300), chan_t'(CHAN_MAX), '0);
    send_pixel('0, '0, '0);
    send_pixel(HUE_BITS'(90), chan_t'(8'haa), chan_t'(8'h55));
    send_pixel(HUE_BITS'(150), chan_t'(8'h55), chan_t'(8'haa));
  endtask

  // Hue values past a full turn fold back by 360.
  task automatic test_hue_wrap();
    send_pixel(HUE_BITS'(FULL_TURN), chan_t'(200), chan_t'(CHAN_MAX));
    send_pixel(HUE_BITS'(FULL_TURN + 1), chan_t'(CHAN_MAX), chan_t'(180));
    send_pixel(HUE_BITS'(420), chan_t'(128), chan_t'(240));
    send_pixel({HUE_BITS{1'b1}}, chan_t'(CHAN_MAX), chan_t'(CHAN_MAX));
  endtask

  task automatic test_random_pixels();
    logic [HUE_BITS-1:0] h;
    int unsigned         roll;
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      // new sender pacing every 250 transfers; style 0 means back to back
      if (n % 250 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_max = 0;
          1:       gap_max = 2;
          2:       gap_max = 6;
          default: gap_max = 12;
        endcase
      end
      roll = $urandom_range(0, 19);
      if (roll < 17)
        h = HUE_BITS'($urandom_range(0, FULL_TURN - 1));
      else if (roll < 19)
        h = HUE_BITS'($urandom_range(FULL_TURN, (1 << HUE_BITS) - 1));
      else
        h = HUE_BITS'(SECTOR_DEG * $urandom_range(0, 6) - $urandom_range(0, 1) + 1);
      send_pixel(h, pick_channel(), pick_channel());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sector_edges();
    test_gray_and_black();
    gap_max = 3;
    test_hue_wrap();
    test_random_pixels();
    in_valid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_rgb.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv_to_rgb_converter_unit.sv
dv/tb_top.sv
